[rtl/tppd_pkg.sv]
// ----------------------------------------------------------------------------
// Task picker package
// Item, result and slot record types, opcodes and constants shared by the
// task picker and its testbench.
// ----------------------------------------------------------------------------
package tppd_pkg;

	localparam int DEF_TASK_SLOTS = 16;

	localparam int SLOT_W  = 4;
	localparam int RATE_W  = 10;
	localparam int PRIO_W  = 8;
	localparam int TICK_W  = 32;
	localparam int HALF_W  = 16;
	localparam int DL_W    = TICK_W + 1;
	localparam int CNT_W   = $clog2(RATE_W);

	localparam logic                OP_WRITE      = 1'b0;
	localparam logic                OP_SELECT     = 1'b1;
	localparam logic [RATE_W-1:0]   RATE_DIVIDEND = RATE_W'(1000);
	localparam logic [PRIO_W-1:0]   PRIO_START    = '1;
	localparam logic [CNT_W-1:0]    DIV_LAST_STEP = CNT_W'(RATE_W - 1);

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic              runnable;
		logic              sem_attached;
		logic [HALF_W-1:0] sem_count;
		logic [HALF_W-1:0] sem_owner;
		logic [HALF_W-1:0] task_id;
		logic [TICK_W-1:0] continue_time;
		logic [PRIO_W-1:0] priority_req;
		logic [RATE_W-1:0] refresh_rate;
		logic [TICK_W-1:0] last_start;
		logic [TICK_W-1:0] now_tick;
	} tppd_item_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] chosen_slot;
	} tppd_result_t;

	// Slot as held in memory: semaphore test and deadline are resolved at write.
	typedef struct packed {
		logic              runnable;
		logic              blocked;
		logic [TICK_W-1:0] resume_time;
		logic [PRIO_W-1:0] prio;
		logic              rate_nz;
		logic [DL_W-1:0]   deadline;
	} tppd_slot_rec_t;

endpackage

[rtl/tppd_ram.sv]
// ----------------------------------------------------------------------------
// Task picker slot memory
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/task_pick_priority_deadline.sv]
// ----------------------------------------------------------------------------
// Fixed-priority task picker with deadline tie rule
// Holds a table of task slots and, per select transaction, scans it for the
// next task to run.
// ----------------------------------------------------------------------------
// A write transaction (op 0) stores one slot and keeps busy high through
// ST_DIV, where the shared restoring divider works out 1000/rate one quotient
// bit a cycle, and ST_WRITE, which writes the slot memory with the semaphore
// test and the deadline (last_start + 1000/rate) already resolved.
// A select transaction (op 1) keeps busy high through ST_SCAN and ST_LAST; the
// scan reads one slot per cycle through the single read port of the slot
// memory, and that port sets the pace. The result is shown with done high
// for exactly one cycle, registered in ST_LAST, and the
// receiver cannot hold it off: capture it on that cycle. A new transaction may
// be accepted in the same cycle as done. Slots come out of reset not runnable
// through a per-slot written flag, so there is no clearing pass. Writes to a
// slot index at or above TASK_SLOTS are dropped.
// ----------------------------------------------------------------------------
module task_pick_priority_deadline
	import tppd_pkg::*;
#(
	parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  tppd_item_t   item,
	output logic         busy,
	output logic         done,
	output tppd_result_t result
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int REC_W = $bits(tppd_slot_rec_t);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_LAST  = 5'b10000
	} state_t;

	state_t state_q;

	// Write transaction holding registers
	logic              wr_ok_q;
	logic [IDX_W-1:0]  wr_addr_q;
	logic              wr_runnable_q;
	logic              wr_blocked_q;
	logic [TICK_W-1:0] wr_resume_q;
	logic [PRIO_W-1:0] wr_prio_q;
	logic [RATE_W-1:0] wr_rate_q;
	logic [TICK_W-1:0] wr_start_q;

	// Shared divider
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] quot_q;
	logic [RATE_W-1:0] dvd_q;
	logic [RATE_W:0]   trial;
	logic              trial_ge;
	logic [RATE_W:0]   trial_sub;

	// Scan state
	logic [TASK_SLOTS-1:0] written_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TICK_W-1:0]     now_q;
	logic [PRIO_W-1:0]     best_prio_q;
	logic                  dl_held_q;
	logic [DL_W-1:0]       best_dl_q;
	logic                  found_q;
	logic [IDX_W-1:0]      chosen_q;

	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  wr_s1;

	logic                  done_q;
	tppd_result_t          result_q;

	// Memory ports
	logic                  ram_wr_en;
	tppd_slot_rec_t        wr_rec;
	logic                  ram_rd_en;
	logic [REC_W-1:0]      ram_rd_data;
	tppd_slot_rec_t        rec_s1;

	// Evaluation
	logic                  accept;
	logic                  dl_ok;
	logic                  take;
	logic                  found_nxt;
	logic [IDX_W-1:0]      chosen_nxt;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// One restoring division step: bring down the next dividend bit, subtract if it fits
	assign trial     = {rem_q, dvd_q[RATE_W-1]};
	assign trial_ge  = (trial >= {1'b0, wr_rate_q});
	assign trial_sub = trial - {1'b0, wr_rate_q};

	always_comb begin
		wr_rec.runnable    = wr_runnable_q;
		wr_rec.blocked     = wr_blocked_q;
		wr_rec.resume_time = wr_resume_q;
		wr_rec.prio        = wr_prio_q;
		wr_rec.rate_nz     = (wr_rate_q != '0);
		wr_rec.deadline    = DL_W'(wr_start_q) + DL_W'(quot_q);
	end

	assign ram_wr_en = (state_q == ST_WRITE) && wr_ok_q;
	assign ram_rd_en = (state_q == ST_SCAN);

	tppd_ram #(
		.WIDTH (REC_W),
		.DEPTH (TASK_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wr_addr_q),
		.wr_data (REC_W'(wr_rec)),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	assign rec_s1 = tppd_slot_rec_t'(ram_rd_data);

	// Skip tests of the scan, taken together: a slot never written is not runnable
	always_comb begin
		if (rec_s1.rate_nz) begin
			dl_ok = !(dl_held_q && (rec_s1.deadline > best_dl_q));
		end else begin
			dl_ok = !dl_held_q;
		end
		take = vld_s1 && wr_s1 && rec_s1.runnable && !rec_s1.blocked
			&& !(rec_s1.resume_time > now_q) && (rec_s1.prio < best_prio_q) && dl_ok;
		found_nxt  = found_q || take;
		chosen_nxt = take ? idx_s1 : chosen_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			written_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						cnt_q <= DIV_LAST_STEP;
						if (item.op == OP_WRITE) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wr_ok_q) begin
						written_q[wr_addr_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_LAST: begin
					// last slot is being judged this cycle: present the result next
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read stage bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wr_s1  <= 1'b0;
		end else begin
			vld_s1 <= ram_rd_en;
			wr_s1  <= written_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// Best-so-far registers: reset at select acceptance, advance on each taken slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			dl_held_q <= 1'b0;
		end else if (accept && (item.op == OP_SELECT)) begin
			found_q   <= 1'b0;
			dl_held_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
			if (rec_s1.rate_nz) begin
				dl_held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.op == OP_SELECT)) begin
			now_q       <= item.now_tick;
			best_prio_q <= PRIO_START;
			chosen_q    <= '0;
		end else if (take) begin
			best_prio_q <= rec_s1.prio;
			chosen_q    <= idx_s1;
			if (rec_s1.rate_nz) begin
				best_dl_q <= rec_s1.deadline;
			end
		end
	end

	// Result register: loaded as the last slot is judged
	always_ff @(posedge clk) begin
		if (state_q == ST_LAST) begin
			result_q.found       <= found_nxt;
			result_q.chosen_slot <= SLOT_W'(chosen_nxt);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Write transaction capture and divider iteration
	always_ff @(posedge clk) begin
		if (accept && (item.op == OP_WRITE)) begin
			wr_ok_q       <= (9'(item.slot) < 9'(TASK_SLOTS));
			wr_addr_q     <= IDX_W'(item.slot);
			wr_runnable_q <= item.runnable;
			wr_blocked_q  <= item.sem_attached && (item.sem_count == '0)
				&& (item.sem_owner != item.task_id);
			wr_resume_q   <= item.continue_time;
			wr_prio_q     <= item.priority_req;
			wr_rate_q     <= item.refresh_rate;
			wr_start_q    <= item.last_start;
			rem_q         <= '0;
			quot_q        <= '0;
			dvd_q         <= RATE_DIVIDEND;
		end else if (state_q == ST_DIV) begin
			rem_q  <= trial_ge ? RATE_W'(trial_sub) : RATE_W'(trial);
			quot_q <= {quot_q[RATE_W-2:0], trial_ge};
			dvd_q  <= {dvd_q[RATE_W-2:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_LAST))
		else $error("done without a finished scan");

	a_select_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.op == OP_SELECT)) |-> ##(TASK_SLOTS + 2) done)
		else $error("select result not delivered on time");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.chosen_slot == '0))
		else $error("chosen slot not zero when nothing was found");

	a_scan_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (busy && ((state_q == ST_SCAN) || (state_q == ST_LAST))))
		else $error("slot judged outside a scan");
`endif

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Task picker testbench
// Loads task slots and issues select transactions against the picker, with a
// slot table and selection scan of its own to predict each pick. A short
// directed run covers the corner cases, then random rounds load slots around
// a common tick and select near it. The sender works in bursts with gaps.
// ----------------------------------------------------------------------------
module tb
	import tppd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_SLOTS   = DEF_TASK_SLOTS;
	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 12;
	localparam int ITEM_TARGET  = 1400;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = TASK_SLOTS + 8;
	localparam int MS_PER_S     = 1000;

	logic         clk;
	logic         arst_n;
	logic         start = 1'b0;
	tppd_item_t   item  = '0;
	logic         busy;
	logic         done;
	tppd_result_t result;

	// Transactions waiting to go out, and picks waiting to come back.
	tppd_item_t   item_backlog_q[$];
	tppd_result_t pick_expect_q[$];

	// Slot table as the predictor sees it: each write stores the whole item.
	tppd_item_t   slot_tbl[TASK_SLOTS];
	tppd_result_t want_pick;

	int unsigned  gap_left    = 0;
	int unsigned  burst_left  = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  err_count   = 0;

	task_pick_priority_deadline #(
		.TASK_SLOTS(TASK_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#(CLK_HALF);
		clk = 1'b1;
		#(CLK_HALF);
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// Scan the slots in index order, keeping the best priority and, once a
	// rated slot is taken, its deadline. The deadline is 33 bits wide so that a
	// start near the top of the tick range does not wrap.
	function automatic tppd_result_t pick_next_task(input logic [TICK_W-1:0] now);
		tppd_result_t     pick;
		logic [PRIO_W-1:0] best_prio;
		logic              dl_held;
		logic [DL_W-1:0]   best_dl;
		logic [DL_W-1:0]   dl;
		pick      = '0;
		best_prio = '1;
		dl_held   = 1'b0;
		best_dl   = '0;
		dl        = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (!slot_tbl[i].runnable)
				continue;
			// Held semaphore that this task does not own
			if (slot_tbl[i].sem_attached && slot_tbl[i].sem_count == '0 &&
					slot_tbl[i].sem_owner != slot_tbl[i].task_id)
				continue;
			if (slot_tbl[i].continue_time > now)
				continue;
			if (slot_tbl[i].priority_req >= best_prio)
				continue;
			if (slot_tbl[i].refresh_rate != '0) begin
				dl = {1'b0, slot_tbl[i].last_start} +
					DL_W'(MS_PER_S / int'(slot_tbl[i].refresh_rate));
				// An equal deadline still wins
				if (dl_held && dl > best_dl)
					continue;
			end else if (dl_held) begin
				continue;
			end
			pick.found       = 1'b1;
			pick.chosen_slot = SLOT_W'(i);
			best_prio        = slot_tbl[i].priority_req;
			if (slot_tbl[i].refresh_rate != '0) begin
				best_dl = dl;
				dl_held = 1'b1;
			end
		end
		return pick;
	endfunction

	// Every field random, rate kept within its legal range.
	function automatic tppd_item_t noise_item();
		tppd_item_t it;
		it.op            = 1'($urandom);
		it.slot          = SLOT_W'($urandom);
		it.runnable      = 1'($urandom);
		it.sem_attached  = 1'($urandom);
		it.sem_count     = HALF_W'($urandom);
		it.sem_owner     = HALF_W'($urandom);
		it.task_id       = HALF_W'($urandom);
		it.continue_time = $urandom;
		it.priority_req  = PRIO_W'($urandom);
		it.refresh_rate  = RATE_W'($urandom_range(0, MS_PER_S));
		it.last_start    = $urandom;
		it.now_tick      = $urandom;
		return it;
	endfunction

	task automatic write_slot(input logic [SLOT_W-1:0] idx, input logic run,
			input logic att, input logic [HALF_W-1:0] cnt,
			input logic [HALF_W-1:0] owner, input logic [HALF_W-1:0] id,
			input logic [TICK_W-1:0] resume, input logic [PRIO_W-1:0] prio,
			input logic [RATE_W-1:0] rate, input logic [TICK_W-1:0] lstart);
		tppd_item_t it;
		it               = noise_item();
		it.op            = OP_WRITE;
		it.slot          = idx;
		it.runnable      = run;
		it.sem_attached  = att;
		it.sem_count     = cnt;
		it.sem_owner     = owner;
		it.task_id       = id;
		it.continue_time = resume;
		it.priority_req  = prio;
		it.refresh_rate  = rate;
		it.last_start    = lstart;
		item_backlog_q.push_back(it);
	endtask

	task automatic select_at(input logic [TICK_W-1:0] now);
		tppd_item_t it;
		it          = noise_item();
		it.op       = OP_SELECT;
		it.now_tick = now;
		item_backlog_q.push_back(it);
	endtask

	// Slot contents clustered round the round's base tick, so that resume
	// times, priorities and deadlines collide often enough to matter.
	function automatic tppd_item_t random_slot_write(input logic [TICK_W-1:0] base,
			input logic [SLOT_W-1:0] idx);
		tppd_item_t it;
		it              = noise_item();
		it.op           = OP_WRITE;
		it.slot         = idx;
		it.runnable     = ($urandom_range(0, 7) != 0);
		it.sem_attached = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 1) == 0)
			it.sem_count = '0;
		if ($urandom_range(0, 1) == 0)
			it.sem_owner = it.task_id;
		case ($urandom_range(0, 9))
			7, 8:    it.continue_time = base + $urandom_range(1, 40);
			9:       it.continue_time = $urandom;
			default: it.continue_time = base - $urandom_range(0, 40);
		endcase
		case ($urandom_range(0, 9))
			0:       it.priority_req = '1;
			1:       it.priority_req = PRIO_W'($urandom);
			default: it.priority_req = PRIO_W'($urandom_range(0, 15));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: it.refresh_rate = '0;
			3:       it.refresh_rate = RATE_W'(MS_PER_S);
			4:       it.refresh_rate = RATE_W'(500);
			5:       it.refresh_rate = RATE_W'(250);
			6:       it.refresh_rate = RATE_W'(1 << $urandom_range(0, 9));
			default: it.refresh_rate = RATE_W'($urandom_range(1, MS_PER_S));
		endcase
		case ($urandom_range(0, 9))
			8:       it.last_start = 32'hFFFF_FFFF - $urandom_range(0, 3);
			9:       it.last_start = $urandom;
			default: it.last_start = base - $urandom_range(0, 2000);
		endcase
		return it;
	endfunction

	// One round: load some slots, sometimes the whole table, then select near
	// the base tick; now and then throw in an unrelated transaction.
	task automatic random_round();
		logic [TICK_W-1:0] base;
		logic              fill_all;
		int                n_wr;
		int                n_sel;
		case ($urandom_range(0, 9))
			0:       base = $urandom_range(0, 100);
			1:       base = 32'hFFFF_FFFF - $urandom_range(0, 100);
			default: base = $urandom;
		endcase
		fill_all = ($urandom_range(0, 19) == 0);
		n_wr     = fill_all ? TASK_SLOTS : $urandom_range(1, 6);
		n_sel    = $urandom_range(1, 3);
		for (int k = 0; k < n_wr; k++)
			item_backlog_q.push_back(random_slot_write(base,
				fill_all ? SLOT_W'(k) : SLOT_W'($urandom)));
		for (int k = 0; k < n_sel; k++) begin
			if ($urandom_range(0, 9) == 0)
				select_at($urandom);
			else
				select_at(base + $urandom_range(0, 60) - 30);
		end
		if ($urandom_range(0, 9) == 0)
			item_backlog_q.push_back(noise_item());
	endtask

	// Driver: present the next transaction and hold it until accepted. Work in
	// bursts; after the last item of a burst, drop start for a random gap. Now
	// and then run a long burst with no gaps at all.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			item       <= '0;
			gap_left   <= 0;
			burst_left <= 0;
		end else if (start && busy) begin
			// hold the transaction until busy drops
		end else if (gap_left != 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (item_backlog_q.size() != 0) begin
			start <= 1'b1;
			item  <= item_backlog_q.pop_front();
			if (burst_left <= 1) begin
				if ($urandom_range(0, 9) == 0) begin
					gap_left   <= 0;
					burst_left <= $urandom_range(100, 300);
				end else begin
					gap_left   <= $urandom_range(1, 25);
					burst_left <= $urandom_range(1, 12);
				end
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check the result shown with done first, since a new select may
	// be accepted on the same edge; then fold the accepted transaction into the
	// slot table or queue its predicted pick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++)
				slot_tbl[i] = '0;
		end else begin
			if (done) begin
				if (pick_expect_q.size() == 0) begin
					report_mismatch("result with no select pending", 32'(result), 0);
				end else begin
					want_pick = pick_expect_q.pop_front();
					if (result.found !== want_pick.found)
						report_mismatch("found", 32'(result.found),
							32'(want_pick.found));
					if (result.chosen_slot !== want_pick.chosen_slot)
						report_mismatch("chosen_slot", 32'(result.chosen_slot),
							32'(want_pick.chosen_slot));
				end
			end
			if (start && !busy) begin
				if (item.op == OP_SELECT)
					pick_expect_q.push_back(pick_next_task(item.now_tick));
				else if (item.slot < TASK_SLOTS)
					slot_tbl[item.slot] = item;
			end
		end
	end

	// Watchdog: give up after a long stretch with no transaction either way.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// Empty table, then a runnable slot at priority 255 that never wins
		select_at(32'h0);
		write_slot(0, 1, 0, 16'h0, 16'h0, 16'h0, 32'h0, 8'hFF, 0, 32'h0);
		select_at(32'h0);
		// Owner holds its own semaphore; resume equal to now is allowed, one
		// tick later is not
		write_slot(15, 1, 1, 16'h0, 16'h1234, 16'h1234, 32'hFFFF_FFFF, 8'h00,
			10'd1000, 32'hFFFF_FFFF);
		select_at(32'hFFFF_FFFF);
		select_at(32'hFFFF_FFFE);
		// Blocked by a foreign owner; a free semaphore with deadline 1000 beats
		// slot 15, whose deadline only fits in 33 bits
		write_slot(3, 1, 1, 16'h0, 16'hFFFF, 16'h0000, 32'h0, 8'd10, 0, 32'h0);
		write_slot(5, 1, 1, 16'h0001, 16'h0005, 16'h0007, 32'h0, 8'd20, 10'd1,
			32'h0);
		select_at(32'hFFFF_FFFF);
		// Equal deadline still taken
		write_slot(7, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 8'd5, 10'd500,
			32'd998);
		select_at(32'hFFFF_FFFF);
		// No rate: skipped once a deadline is held, taken before one is
		write_slot(9, 1, 0, 16'h0, 16'h0, 16'h0, 32'h0, 8'd1, 0, 32'h0);
		write_slot(2, 1, 0, 16'h0, 16'h0, 16'h0, 32'h0, 8'd30, 0, 32'h0);
		select_at(32'd1000);
		write_slot(7, 0, 0, 16'h0, 16'h0, 16'h0, 32'h0, 8'd0, 10'd1000, 32'h0);
		select_at(32'h8000_0000);
		write_slot(5, 1, 1, 16'h0, 16'hBEEF, 16'hBEEE, 32'h0, 8'd20, 10'd1, 32'h0);
		select_at(32'h8000_0000);
		write_slot(4, 1, 0, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 8'd0, 10'd3,
			32'h7FFF_FFFF);
		select_at(32'h7FFF_FFFF);
		select_at(32'h7FFF_FFFE);

		while (item_backlog_q.size() < ITEM_TARGET)
			random_round();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: everything sent, nothing in flight, every pick returned
		while (item_backlog_q.size() != 0 || start || pick_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
